// ===== rtl/core/go_back_n_sender_assert.svh =====
// assertion helpers for the go-back-n sender checker
`ifndef GO_BACK_N_SENDER_ASSERT_SVH
`define GO_BACK_N_SENDER_ASSERT_SVH

// same-cycle implication
`define GBN_ASSERT_IMP(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("go-back-n sender check failed");

// next-cycle implication
`define GBN_ASSERT_NXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("go-back-n sender check failed");

`endif

// ===== rtl/core/gbn_pkg.sv =====
`default_nettype none

package gbn_pkg;

  localparam int unsigned MAX_WINDOW    = 32;
  localparam int unsigned LEN_BITS      = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CQ_DEPTH      = 2;
  localparam int unsigned CQ_PTR_BITS   = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam logic [23:0] COUNT_MAX = 24'hFF_FFFF;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_SIZE  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_TOTAL_FRAMES = CFG_IDX_BITS'(1);

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    RK_SEND    = 2'd0,
    RK_ACKED   = 2'd1,
    RK_DONE    = 2'd2,
    RK_IGNORED = 2'd3
  } result_kind_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] ack_number;
  } in_t;

  typedef struct packed {
    result_kind_e result_kind;
    logic [15:0]  frame_number;
    logic [23:0]  transmit_count;
    logic         last_of_run;
  } out_t;

  // one run of results for the back end
  typedef struct packed {
    result_kind_e        kind;
    logic [15:0]         frame;
    logic [LEN_BITS-1:0] len;
    logic [23:0]         count;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/go_back_n_sender.sv =====
// Go-Back-N ARQ sender. Events (start, ack, timeout) go in through a queue-style port
// (push/full) and result words come out through another (empty/pop); configuration is
// written on the cfg port (index 0 window_size, index 1 total_frames); the user must
// do so only while the block is idle, as the block itself does not enforce it. The
// front end takes one event when it is idle and the two-entry command queue has room:
// an ack-accepted or ignored event is pushed at once, an event that starts a burst or
// reports completion takes three steps (base update, round end, issue, which waits on a
// full queue). The back end loads a command and then, while its single output register
// is free or popped, emits one result word per cycle, up to a 32-frame window per run.
`default_nettype none

module go_back_n_sender (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                push,
  input  gbn_pkg::in_t                       in_word_i,
  output logic                               full,
  output logic                               empty,
  input  wire                                pop,
  output gbn_pkg::out_t                      out_word_o,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [gbn_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire  [gbn_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);
  import gbn_pkg::*;

  logic ev_ready;
  cmd_t fr_cmd, bk_cmd;
  logic fr_push, cq_full, cq_empty, bk_pop;

  assign full        = !ev_ready;
  assign cfg_ready_o = 1'b1;

  gbn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ev_push_i   (push),
    .ev_i        (in_word_i),
    .ev_ready_o  (ev_ready),
    .cmd_o       (fr_cmd),
    .cmd_push_o  (fr_push),
    .cmd_full_i  (cq_full)
  );

  gbn_cmd_fifo u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .cmd_i   (fr_cmd),
    .full_o  (cq_full),
    .pop_i   (bk_pop),
    .cmd_o   (bk_cmd),
    .empty_o (cq_empty)
  );

  gbn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (bk_cmd),
    .cmd_empty_i (cq_empty),
    .cmd_pop_o   (bk_pop),
    .empty       (empty),
    .pop         (pop),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/gbn_front.sv =====
`default_nettype none

module gbn_front (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_valid_i,
  input  wire  [gbn_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  wire  [gbn_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  wire                                 ev_push_i,
  input  gbn_pkg::in_t                        ev_i,
  output logic                                ev_ready_o,
  output gbn_pkg::cmd_t                       cmd_o,
  output logic                                cmd_push_o,
  input  wire                                 cmd_full_i
);
  import gbn_pkg::*;

  localparam logic [1:0] FS_IDLE  = 2'd0;
  localparam logic [1:0] FS_PREP  = 2'd1;
  localparam logic [1:0] FS_ISSUE = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [5:0]  win_q;
  logic [15:0] total_q;
  logic [16:0] base_q, exp_q, rend_q;
  logic [5:0]  acked_q;
  logic        wait_q;
  logic [23:0] sent_q;
  logic [16:0] end_q;
  logic        done_q;

  logic        accept;
  logic        is_start, is_bad, ack_hit;
  logic [5:0]  win_eff;
  logic [16:0] total_x, sum_end, end_d, span;
  logic [LEN_BITS-1:0] run_len;
  logic [24:0] sent_sum;
  logic [23:0] sent_next;

  assign ev_ready_o = (state_q == FS_IDLE) && !cmd_full_i;
  assign accept     = ev_push_i && ev_ready_o;
  assign is_start   = ev_i.operation == OP_START;
  assign is_bad     = (ev_i.operation != OP_START) && (ev_i.operation != OP_ACK) &&
                      (ev_i.operation != OP_TIMEOUT);
  assign ack_hit    = (ev_i.operation == OP_ACK) && ({1'b0, ev_i.ack_number} == exp_q);

  assign win_eff = (win_q == 6'd0) ? 6'd1 :
                   (32'(win_q) > MAX_WINDOW) ? 6'(MAX_WINDOW) : win_q;
  assign total_x = {1'b0, total_q};
  assign sum_end = base_q + 17'(win_eff) - 17'd1;
  assign end_d   = (sum_end > total_x) ? total_x : sum_end;

  assign span      = end_q - base_q + 17'd1;
  assign run_len   = span[LEN_BITS-1:0];
  assign sent_sum  = {1'b0, sent_q} + 25'(run_len);
  assign sent_next = sent_sum[24] ? COUNT_MAX : sent_sum[23:0];

  always_comb begin
    cmd_o      = '{kind: RK_IGNORED, frame: 16'd0, len: LEN_BITS'(1), count: sent_q};
    cmd_push_o = 1'b0;
    state_d    = state_q;
    unique case (state_q)
      FS_IDLE: begin
        if (accept) begin
          if (is_start) begin
            state_d = FS_PREP;
          end else if (is_bad || !wait_q) begin
            cmd_push_o = 1'b1;
          end else if (ack_hit && (exp_q < rend_q)) begin
            cmd_o.kind  = RK_ACKED;
            cmd_o.frame = ev_i.ack_number;
            cmd_push_o  = 1'b1;
          end else begin
            state_d = FS_PREP;
          end
        end
      end
      FS_PREP: begin
        state_d = FS_ISSUE;
      end
      FS_ISSUE: begin
        if (!cmd_full_i) begin
          cmd_push_o = 1'b1;
          state_d    = FS_IDLE;
          if (done_q) begin
            cmd_o.kind = RK_DONE;
          end else begin
            cmd_o.kind  = RK_SEND;
            cmd_o.frame = base_q[15:0];
            cmd_o.len   = run_len;
          end
        end
      end
      default: begin
        state_d = FS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      win_q   <= 6'd4;
      total_q <= 16'd16;
      base_q  <= 17'd1;
      exp_q   <= 17'd1;
      rend_q  <= 17'd0;
      acked_q <= 6'd0;
      wait_q  <= 1'b0;
      sent_q  <= 24'd0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_WINDOW_SIZE) begin
          win_q <= cfg_data_i[5:0];
        end else if (cfg_index_i == CFG_TOTAL_FRAMES) begin
          total_q <= cfg_data_i[15:0];
        end
      end
      if (state_q == FS_IDLE && accept) begin
        if (is_start) begin
          base_q <= 17'd1;
          sent_q <= 24'd0;
        end else if (is_bad || !wait_q) begin
          // idle or unknown event: nothing changes
        end else if (ack_hit) begin
          acked_q <= acked_q + 6'd1;
          if (exp_q >= rend_q) begin
            base_q <= rend_q + 17'd1;
          end else begin
            exp_q <= exp_q + 17'd1;
          end
        end else begin
          base_q <= base_q + 17'(acked_q);
        end
      end
      if (state_q == FS_ISSUE && !cmd_full_i) begin
        if (done_q) begin
          wait_q <= 1'b0;
        end else begin
          sent_q  <= sent_next;
          rend_q  <= end_q;
          exp_q   <= base_q;
          acked_q <= 6'd0;
          wait_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FS_PREP) begin
      end_q  <= end_d;
      done_q <= base_q > total_x;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gbn_cmd_fifo.sv =====
`default_nettype none

module gbn_cmd_fifo (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  gbn_pkg::cmd_t  cmd_i,
  output logic           full_o,
  input  wire            pop_i,
  output gbn_pkg::cmd_t  cmd_o,
  output logic           empty_o
);
  import gbn_pkg::*;

  localparam logic [CQ_PTR_BITS-1:0] LAST_PTR = CQ_PTR_BITS'(CQ_DEPTH - 1);

  cmd_t                  mem_q [CQ_DEPTH];
  logic [CQ_PTR_BITS-1:0] wptr_q, rptr_q;
  logic [CQ_PTR_BITS:0]   cnt_q;
  logic                   do_push, do_pop;

  assign full_o  = cnt_q == (CQ_PTR_BITS + 1)'(CQ_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (CQ_PTR_BITS + 1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (CQ_PTR_BITS + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gbn_back.sv =====
`default_nettype none

module gbn_back (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  gbn_pkg::cmd_t  cmd_i,
  input  wire            cmd_empty_i,
  output logic           cmd_pop_o,
  output logic           empty,
  input  wire            pop,
  output gbn_pkg::out_t  out_word_o
);
  import gbn_pkg::*;

  logic                busy_q, out_valid_q;
  result_kind_e        kind_q;
  logic [15:0]         frame_q;
  logic [LEN_BITS-1:0] rem_q;
  logic [23:0]         cnt_q;
  out_t                out_q;

  logic        step, last;
  logic [24:0] cnt_inc;
  logic [23:0] cnt_next;

  assign step      = busy_q && (!out_valid_q || pop);
  assign cmd_pop_o = !busy_q && !cmd_empty_i;
  assign last      = rem_q == LEN_BITS'(1);
  assign cnt_inc   = {1'b0, cnt_q} + 25'd1;
  assign cnt_next  = (kind_q != RK_SEND) ? cnt_q :
                     cnt_inc[24] ? COUNT_MAX : cnt_inc[23:0];

  assign empty      = !out_valid_q;
  assign out_word_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        out_valid_q <= 1'b1;
        busy_q      <= !last;
      end else begin
        if (pop) begin
          out_valid_q <= 1'b0;
        end
        if (cmd_pop_o) begin
          busy_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      kind_q  <= cmd_i.kind;
      frame_q <= cmd_i.frame;
      rem_q   <= cmd_i.len;
      cnt_q   <= cmd_i.count;
    end else if (step) begin
      out_q.result_kind    <= kind_q;
      out_q.frame_number   <= frame_q;
      out_q.transmit_count <= cnt_next;
      out_q.last_of_run    <= last;
      cnt_q                <= cnt_next;
      frame_q              <= frame_q + 16'd1;
      rem_q                <= rem_q - LEN_BITS'(1);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gbn_checker.sv =====
`default_nettype none

`include "go_back_n_sender_assert.svh"

module gbn_checker (
  input wire            clk_i,
  input wire            rst_ni,
  input wire            empty,
  input wire            pop,
  input gbn_pkg::out_t  out_word_o
);
  import gbn_pkg::*;

  // a waiting word holds until taken
  `GBN_ASSERT_NXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_word_o))

  // completion and ignored words carry no frame
  `GBN_ASSERT_IMP(a_no_frame, clk_i, rst_ni,
    !empty && (out_word_o.result_kind == RK_DONE || out_word_o.result_kind == RK_IGNORED),
    out_word_o.frame_number == 16'd0)

  // anything but a send stands alone in its run
  `GBN_ASSERT_IMP(a_single_last, clk_i, rst_ni,
    !empty && out_word_o.result_kind != RK_SEND, out_word_o.last_of_run)

  // a burst continues with the next frame right away
  `GBN_ASSERT_NXT(a_burst_seq, clk_i, rst_ni,
    !empty && pop && out_word_o.result_kind == RK_SEND && !out_word_o.last_of_run,
    !empty && out_word_o.result_kind == RK_SEND &&
    out_word_o.frame_number == $past(out_word_o.frame_number) + 16'd1)

endmodule

bind go_back_n_sender gbn_checker u_gbn_checker (.*);

`default_nettype wire
